/* rtl/ellipse_midpoint_rasterizer_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the ellipse rasterizer
// Concurrent checks, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ELLIPSE_MIDPOINT_RASTERIZER_TOP_MACROS_SVH
`define ELLIPSE_MIDPOINT_RASTERIZER_TOP_MACROS_SVH

`ifndef SYNTH

// plain property, checked on every clock edge out of reset
`define EMR_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define EMR_ASSERT_IMP(name, clk, rst, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define EMR_ASSERT_NXT(name, clk, rst, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`else

`define EMR_ASSERT(name, clk, rst, prop, msg)
`define EMR_ASSERT_IMP(name, clk, rst, pre, post, msg)
`define EMR_ASSERT_NXT(name, clk, rst, pre, post, msg)

`endif

`endif

/* rtl/emr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emr_pkg
// Shared types and constants of the midpoint ellipse rasterizer.
// ----------------------------------------------------------------------------
package emr_pkg;

  localparam int PAINT_W = 8;

  // decision variable width and its saturation limits
  localparam int DEC_W = 36;
  localparam logic [DEC_W-1:0] DEC_MAX = {1'b0, {(DEC_W-1){1'b1}}};
  localparam logic [DEC_W-1:0] DEC_MIN = {1'b1, {(DEC_W-1){1'b0}}};

  // input word kinds
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  typedef struct packed {
    logic last;
    logic valid_res;
  } emr_flags_t;

endpackage

/* rtl/emr_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emr_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module emr_mul #(
  parameter int OPW = 23
) (
  input  logic                     clk,
  input  logic signed [OPW-1:0]    a,
  input  logic signed [OPW-1:0]    b,
  output logic signed [2*OPW-1:0]  p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

/* rtl/emr_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emr_core
// Sequencer, ellipse state and decision update around one shared multiplier.
// ----------------------------------------------------------------------------
`include "ellipse_midpoint_rasterizer_top_macros.svh"

module emr_core #(
  parameter int COORD_BITS = 12,
  parameter int AXIS_BITS  = 10
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_action,
  input  logic signed [COORD_BITS-1:0]       in_cx,
  input  logic signed [COORD_BITS-1:0]       in_cy,
  input  logic [AXIS_BITS-1:0]               in_rx,
  input  logic [AXIS_BITS-1:0]               in_ry,
  input  logic [emr_pkg::PAINT_W-1:0]        in_paint,
  output logic                               res_valid,
  input  logic                               res_ready,
  output logic signed [COORD_BITS:0]         res_xp,
  output logic signed [COORD_BITS:0]         res_xm,
  output logic signed [COORD_BITS:0]         res_yp,
  output logic signed [COORD_BITS:0]         res_ym,
  output logic [emr_pkg::PAINT_W-1:0]        res_paint,
  output emr_pkg::emr_flags_t                res_flags
);

  localparam int A     = AXIS_BITS;
  localparam int C     = COORD_BITS;
  localparam int OFF_W = A + 1;
  localparam int SQ_W  = 2 * A;
  localparam int SS_W  = 2 * A + 1;
  localparam int Q_W   = A + 1;
  localparam int T2_W  = 2 * A + 2;
  localparam int MW    = 2 * A + 3;
  localparam int PW    = 2 * MW;
  localparam int DW    = emr_pkg::DEC_W;
  localparam int SW    = (3 * A + 6 > DW + 2) ? 3 * A + 6 : DW + 2;
  localparam int CNT_W = $clog2(A + 1);
  localparam int EW    = ((C > OFF_W) ? C : OFF_W) + 1;

  typedef enum logic [15:0] {
    ST_IDLE = 16'h0001,
    ST_SQA  = 16'h0002,
    ST_SQB  = 16'h0004,
    ST_NN   = 16'h0008,
    ST_NNC  = 16'h0010,
    ST_TT   = 16'h0020,
    ST_TS   = 16'h0040,
    ST_CMP  = 16'h0080,
    ST_D0   = 16'h0100,
    ST_D1   = 16'h0200,
    ST_P1   = 16'h0400,
    ST_P2   = 16'h0800,
    ST_P3   = 16'h1000,
    ST_R2A  = 16'h2000,
    ST_R2B  = 16'h4000,
    ST_EMIT = 16'h8000
  } state_t;

  state_t state;
  logic   running;
  logic   second;
  logic   bound_y;
  logic   res_zero;
  logic   res_last;

  logic signed [C-1:0]              org_x;
  logic signed [C-1:0]              org_y;
  logic [emr_pkg::PAINT_W-1:0]      held_paint;
  logic [A-1:0]                     semi_x;
  logic [A-1:0]                     semi_y;
  logic [SQ_W-1:0]                  sx_sq;
  logic [SQ_W-1:0]                  sy_sq;
  logic [SS_W-1:0]                  sum_sq;
  logic [A-1:0]                     limit_x;
  logic [A-1:0]                     limit_y;
  logic signed [OFF_W-1:0]          off_x;
  logic signed [OFF_W-1:0]          off_y;
  logic signed [DW-1:0]             decision;
  logic signed [PW-1:0]             nn;
  logic [Q_W-1:0]                   q;
  logic [CNT_W-1:0]                 bitcnt;
  logic signed [SW-1:0]             p1;

  logic signed [MW-1:0]             mul_a;
  logic signed [MW-1:0]             mul_b;
  logic signed [PW-1:0]             mul_p;
  logic signed [SW-1:0]             prod_w;

  logic signed [OFF_W-1:0]          u;
  logic signed [OFF_W-1:0]          v;
  logic [SQ_W-1:0]                  sq_u;
  logic [SQ_W-1:0]                  sq_v;
  logic signed [OFF_W+1:0]          inc_k;
  logic signed [OFF_W:0]            vm1;
  logic signed [OFF_W:0]            u_next;
  logic signed [OFF_W-1:0]          v_next;
  logic                             dneg;
  logic signed [SW-1:0]             dec_w;
  logic signed [SW-1:0]             sub_w;
  logic signed [SW-1:0]             step_sum;
  logic signed [SW-1:0]             sqa_w;
  logic signed [SW-1:0]             sqb_w;
  logic signed [SW-1:0]             qa_w;
  logic signed [SW-1:0]             qb_w;
  logic                             x_ok;
  logic                             y_done;
  logic [SQ_W-1:0]                  nsel;
  logic [Q_W-1:0]                   t;
  logic                             t_ok;
  logic [Q_W-1:0]                   q_fin;
  logic [A-1:0]                     lim;
  logic signed [EW-1:0]             xp_w;
  logic signed [EW-1:0]             xm_w;
  logic signed [EW-1:0]             yp_w;
  logic signed [EW-1:0]             ym_w;

  function automatic logic signed [DW-1:0] sat_dec(input logic signed [SW-1:0] x);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &x[SW-1:DW-1];
    hi_zeros = ~|x[SW-1:DW-1];
    if (hi_ones || hi_zeros) begin
      return x[DW-1:0];
    end else if (x[SW-1]) begin
      return emr_pkg::DEC_MIN;
    end else begin
      return emr_pkg::DEC_MAX;
    end
  endfunction

  emr_mul #(.OPW(MW)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  assign prod_w = SW'(mul_p);

  // region one walks x (u) and drops y (v); region two swaps the roles
  assign u      = second ? off_y : off_x;
  assign v      = second ? off_x : off_y;
  assign sq_u   = second ? sx_sq : sy_sq;
  assign sq_v   = second ? sy_sq : sx_sq;
  assign inc_k  = ((OFF_W+2)'(u) <<< 1) + (OFF_W+2)'(3);
  assign vm1    = (OFF_W+1)'(v) - (OFF_W+1)'(1);
  assign dneg   = decision[DW-1];
  assign u_next = (OFF_W+1)'(u) + (OFF_W+1)'(1);
  assign v_next = dneg ? v : v - OFF_W'(1);

  assign dec_w    = SW'(decision);
  assign sub_w    = dneg ? '0 : (prod_w <<< 1);
  assign step_sum = dec_w + p1 - sub_w;
  assign sqa_w    = SW'(sx_sq);
  assign sqb_w    = SW'(sy_sq);
  assign qa_w     = SW'(sx_sq >> 2);
  assign qb_w     = SW'(sy_sq >> 2);

  assign x_ok   = u_next <= signed'({2'b00, limit_x});
  assign y_done = u_next >= signed'({2'b00, limit_y});

  // bound search: one trial bit per pass, t*t then t*t*s against n*n
  assign nsel  = bound_y ? sy_sq : sx_sq;
  assign t     = q | (Q_W'(1) << bitcnt);
  assign t_ok  = mul_p <= nn;
  assign q_fin = t_ok ? t : q;
  assign lim   = (sum_sq == '0) ? '0 : q_fin[A-1:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_SQA: begin
        mul_a = MW'(semi_x);
        mul_b = MW'(semi_x);
      end
      ST_SQB: begin
        mul_a = MW'(semi_y);
        mul_b = MW'(semi_y);
      end
      ST_NN: begin
        mul_a = MW'(nsel);
        mul_b = MW'(nsel);
      end
      ST_NNC, ST_TT: begin
        mul_a = MW'(t);
        mul_b = MW'(t);
      end
      ST_TS: begin
        mul_a = MW'(mul_p[T2_W-1:0]);
        mul_b = MW'(sum_sq);
      end
      ST_D0: begin
        mul_a = MW'(sx_sq);
        mul_b = MW'(semi_y);
      end
      ST_P1: begin
        mul_a = MW'(inc_k);
        mul_b = MW'(sq_u);
      end
      ST_P2: begin
        mul_a = MW'(vm1);
        mul_b = MW'(sq_v);
      end
      ST_R2A: begin
        mul_a = MW'(semi_x);
        mul_b = MW'(sy_sq);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      running  <= 1'b0;
      second   <= 1'b0;
      bound_y  <= 1'b0;
      res_zero <= 1'b0;
      res_last <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (in_action == emr_pkg::ACT_START) begin
              org_x      <= in_cx;
              org_y      <= in_cy;
              held_paint <= in_paint;
              semi_x     <= in_rx;
              semi_y     <= in_ry;
              bound_y    <= 1'b0;
              state      <= ST_SQA;
            end else if (!running) begin
              res_zero <= 1'b1;
              res_last <= 1'b0;
              state    <= ST_EMIT;
            end else begin
              state <= ST_P1;
            end
          end
        end
        ST_SQA: begin
          state <= ST_SQB;
        end
        ST_SQB: begin
          sx_sq <= mul_p[SQ_W-1:0];
          state <= ST_NN;
        end
        ST_NN: begin
          if (!bound_y) begin
            sy_sq  <= mul_p[SQ_W-1:0];
            sum_sq <= SS_W'(sx_sq) + SS_W'(mul_p[SQ_W-1:0]);
          end
          q      <= '0;
          bitcnt <= CNT_W'(A);
          state  <= ST_NNC;
        end
        ST_NNC: begin
          nn    <= mul_p;
          state <= ST_TS;
        end
        ST_TT: begin
          state <= ST_TS;
        end
        ST_TS: begin
          state <= ST_CMP;
        end
        ST_CMP: begin
          q <= q_fin;
          if (bitcnt == '0) begin
            if (!bound_y) begin
              limit_x <= lim;
              bound_y <= 1'b1;
              state   <= ST_NN;
            end else begin
              limit_y <= lim;
              state   <= ST_D0;
            end
          end else begin
            bitcnt <= bitcnt - CNT_W'(1);
            state  <= ST_TT;
          end
        end
        ST_D0: begin
          state <= ST_D1;
        end
        ST_D1: begin
          decision <= sat_dec(sqb_w - prod_w + qa_w);
          off_x    <= '0;
          off_y    <= OFF_W'(semi_y);
          second   <= 1'b0;
          running  <= 1'b1;
          res_zero <= 1'b0;
          res_last <= 1'b0;
          state    <= ST_EMIT;
        end
        ST_P1: begin
          state <= ST_P2;
        end
        ST_P2: begin
          p1    <= prod_w;
          state <= ST_P3;
        end
        ST_P3: begin
          decision <= sat_dec(step_sum);
          res_zero <= 1'b0;
          if (!second) begin
            off_x <= u_next[OFF_W-1:0];
            off_y <= v_next;
            if (x_ok) begin
              res_last <= 1'b0;
              state    <= ST_EMIT;
            end else begin
              state <= ST_R2A;
            end
          end else begin
            off_y    <= u_next[OFF_W-1:0];
            off_x    <= v_next;
            res_last <= y_done;
            if (y_done) begin
              running <= 1'b0;
            end
            state <= ST_EMIT;
          end
        end
        ST_R2A: begin
          state <= ST_R2B;
        end
        ST_R2B: begin
          // region two opens at (a,0); a zero bound ends the ellipse at once
          decision <= sat_dec(sqa_w - prod_w + qb_w);
          second   <= 1'b1;
          off_x    <= OFF_W'(semi_x);
          off_y    <= '0;
          res_last <= (limit_y == '0);
          if (limit_y == '0) begin
            running <= 1'b0;
          end
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign xp_w = EW'(org_x) + EW'(off_x);
  assign xm_w = EW'(org_x) - EW'(off_x);
  assign yp_w = EW'(org_y) + EW'(off_y);
  assign ym_w = EW'(org_y) - EW'(off_y);

  assign in_ready            = (state == ST_IDLE);
  assign res_valid           = (state == ST_EMIT);
  assign res_xp              = res_zero ? '0 : xp_w[C:0];
  assign res_xm              = res_zero ? '0 : xm_w[C:0];
  assign res_yp              = res_zero ? '0 : yp_w[C:0];
  assign res_ym              = res_zero ? '0 : ym_w[C:0];
  assign res_paint           = res_zero ? '0 : held_paint;
  assign res_flags.valid_res = !res_zero;
  assign res_flags.last      = res_last && !res_zero;

  `EMR_ASSERT_NXT(a_last_ends_run, clk, rst, res_valid && res_ready && res_flags.last, !running, "running still set after the final point")
  `EMR_ASSERT_IMP(a_idle_word_blank, clk, rst, res_valid && !res_flags.valid_res, !res_flags.last && res_paint == '0, "blank word carries last or paint")
  `EMR_ASSERT_IMP(a_bound_in_axis, clk, rst, state == ST_D0, limit_x <= semi_x && limit_y <= semi_y, "region bound exceeds its semi-axis")
  `EMR_ASSERT_NXT(a_busy_after_take, clk, rst, in_valid && in_ready, !in_ready, "input taken twice in a row")

endmodule

/* rtl/ellipse_midpoint_rasterizer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ellipse_midpoint_rasterizer_top
// Midpoint ellipse rasterizer: one four-way mirrored point per input word.
// ----------------------------------------------------------------------------
// A start word (tuser = 0) loads center, semi-axes and color and answers with
// point (0,b); each step word (tuser = 1) answers with the next point, the
// final one flagged by tlast; steps after that, or before any start, answer
// with tuser = 0 and all-zero data. One word is in flight at a time, and all
// multiplications go through one shared registered multiplier, one product per
// cycle. A start word first runs a bit-by-bit search for the two region
// bounds; the step that enters region two also passes through the states
// ST_R2A and ST_R2B, and a step with no ellipse running goes straight to the
// output. The input is ready again in the cycle after the output register is
// loaded. The output register holds a finished word while the core works on
// the next one; the core waits in its emit state only while that register is
// still full.
// ----------------------------------------------------------------------------
module ellipse_midpoint_rasterizer_top #(
  parameter int COORD_BITS = 12,
  parameter int AXIS_BITS  = 10,
  localparam int IN_W  = ((2 * COORD_BITS + 2 * AXIS_BITS + emr_pkg::PAINT_W + 7) / 8) * 8,
  localparam int OUT_W = ((8 * (COORD_BITS + 1) + emr_pkg::PAINT_W + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // center_x, center_y, radius_x, radius_y, paint, zero pad
  input  logic [IN_W-1:0]  s_tdata,
  // action
  input  logic             s_tuser,
  output logic             m_tvalid,
  input  logic             m_tready,
  // px_a, py_a, px_b, py_b, px_c, py_c, px_d, py_d, paint_out, zero pad
  output logic [OUT_W-1:0] m_tdata,
  // valid_res
  output logic             m_tuser,
  output logic             m_tlast
);

  localparam int C  = COORD_BITS;
  localparam int A  = AXIS_BITS;
  localparam int PW = emr_pkg::PAINT_W;

  logic                  res_valid;
  logic                  res_ready;
  logic signed [C:0]     res_xp;
  logic signed [C:0]     res_xm;
  logic signed [C:0]     res_yp;
  logic signed [C:0]     res_ym;
  logic [PW-1:0]         res_paint;
  emr_pkg::emr_flags_t   res_flags;
  logic [OUT_W-1:0]      res_word;

  emr_core #(
    .COORD_BITS (COORD_BITS),
    .AXIS_BITS  (AXIS_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_action (s_tuser),
    .in_cx     (s_tdata[C-1:0]),
    .in_cy     (s_tdata[2*C-1:C]),
    .in_rx     (s_tdata[2*C+A-1:2*C]),
    .in_ry     (s_tdata[2*C+2*A-1:2*C+A]),
    .in_paint  (s_tdata[2*C+2*A+PW-1:2*C+2*A]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_xp    (res_xp),
    .res_xm    (res_xm),
    .res_yp    (res_yp),
    .res_ym    (res_ym),
    .res_paint (res_paint),
    .res_flags (res_flags)
  );

  // a=(+x,+y) b=(-x,+y) c=(+x,-y) d=(-x,-y)
  assign res_word = OUT_W'({res_paint, res_ym, res_xm, res_ym, res_xp,
                            res_yp, res_xm, res_yp, res_xp});

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= res_word;
      m_tuser <= res_flags.valid_res;
      m_tlast <= res_flags.last;
    end
  end

endmodule
